// File: rtl/dcbc_pkg.sv
// Shared constants, DES tables and bit-selection functions for the DES-CBC decryptor.
package dcbc_pkg;

   localparam int BLOCK_W = 64;
   localparam int HALF_W  = 32;
   localparam int CD_W    = 56;
   localparam int KEY_W   = 48;
   localparam int ROUNDS  = 16;
   localparam int CNT_W   = 4;

   // Register indexes of the configuration port
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DES_KEY     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_VECTOR = 1'b1;

   localparam logic [6:0] IP_TAB [64] = '{
      7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
      7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
      7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
      7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

   localparam logic [6:0] FP_TAB [64] = '{
      7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
      7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
      7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
      7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
      7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
      7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
      7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
      7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

   localparam logic [5:0] EXP_TAB [48] = '{
      6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
      6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
      6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
      6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
      6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
      6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

   localparam logic [6:0] PC1_TAB [56] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
      7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
      7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
      7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
      7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
      7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
      7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

   localparam logic [5:0] PC2_TAB [48] = '{
      6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
      6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
      6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
      6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
      6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
      6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
      6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
      6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};

   localparam logic [5:0] PPERM_TAB [32] = '{
      6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
      6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
      6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
      6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};

   localparam logic [1:0] SHIFT_TAB [16] = '{
      2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
      2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1};

   localparam logic [3:0] SBOX_TAB [8][64] = '{
      '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
      '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
      '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
      '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
      '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
      '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
      '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
      '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

   // Table entries are 1-based from the most significant bit
   function automatic logic [63:0] ip_perm(input logic [63:0] src);
      logic [63:0] res;
      for (int i = 0; i < 64; i++) res[63-i] = src[6'(64 - IP_TAB[i])];
      return res;
   endfunction

   function automatic logic [63:0] fp_perm(input logic [63:0] src);
      logic [63:0] res;
      for (int i = 0; i < 64; i++) res[63-i] = src[6'(64 - FP_TAB[i])];
      return res;
   endfunction

   function automatic logic [55:0] pc1_perm(input logic [63:0] src);
      logic [55:0] res;
      for (int i = 0; i < 56; i++) res[55-i] = src[6'(64 - PC1_TAB[i])];
      return res;
   endfunction

   function automatic logic [47:0] pc2_perm(input logic [55:0] src);
      logic [47:0] res;
      for (int i = 0; i < 48; i++) res[47-i] = src[6'(56 - PC2_TAB[i])];
      return res;
   endfunction

   function automatic logic [47:0] expand(input logic [31:0] src);
      logic [47:0] res;
      for (int i = 0; i < 48; i++) res[47-i] = src[5'(32 - EXP_TAB[i])];
      return res;
   endfunction

   function automatic logic [31:0] p_perm(input logic [31:0] src);
      logic [31:0] res;
      for (int i = 0; i < 32; i++) res[31-i] = src[5'(32 - PPERM_TAB[i])];
      return res;
   endfunction

   // Row from the outer bits, column from the inner four
   function automatic logic [31:0] sbox_layer(input logic [47:0] x);
      logic [31:0] res;
      logic [5:0]  six;
      for (int i = 0; i < 8; i++) begin
         six = x[47-6*i -: 6];
         res[31-4*i -: 4] = SBOX_TAB[i][{six[5], six[0], six[4:1]}];
      end
      return res;
   endfunction

   function automatic logic [27:0] rotr28(input logic [27:0] v, input logic [1:0] amt);
      return (amt == 2'd2) ? {v[1:0], v[27:2]} : {v[0], v[27:1]};
   endfunction

endpackage

// File: rtl/dcbc_if.sv
// Valid/ready channel interfaces for ciphertext requests and plaintext responses.
interface dcbc_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] cipher_block;
   logic        start_of_message;
   logic        last_block;

   modport source (output valid, output cipher_block, output start_of_message,
                   output last_block, input ready);
   modport sink   (input valid, input cipher_block, input start_of_message,
                   input last_block, output ready);
endinterface

interface dcbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] plain_block;
   logic        last_out;

   modport source (output valid, output plain_block, output last_out, input ready);
   modport sink   (input valid, input plain_block, input last_out, output ready);
endinterface

// File: rtl/des_cbc_decrypt_top.sv
// DES-CBC decryptor top level: configuration registers, round sequencer and output register.
//
// Usage:
//   req_ch carries one 64-bit ciphertext block per item, with start_of_message
//   (chain from the IV) and last_block (copied to last_out). rsp_ch returns one
//   plaintext item per request item, in order.
//   csr_we/csr_index/csr_wdata write des_key (index 0) and init_vector
//   (index 1); write them only while no block is in flight.
// Timing:
//   An accepted block runs 16 Feistel rounds, one per cycle through the single
//   shared round unit, then the finish state loads the output register once
//   it is free. req_ch.ready is high only while the sequencer is idle, so a
//   new block is taken only after the previous one leaves the finish state.
// Stall:
//   A waiting result sits in the output register while the next block is
//   taken and decrypted; the sequencer holds in its finish state until the
//   output register is free.
// Reset:
//   Key, IV and chain value clear to zero; no result is pending.
module des_cbc_decrypt_top (
   input  logic                              clock,
   input  logic                              reset,
   dcbc_req_if.sink                          req_ch,
   dcbc_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [dcbc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [63:0]                       csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] key_ff, key_in;
   logic [63:0] iv_ff, iv_in;
   logic [63:0] chain_ff, chain_in;
   logic [31:0] l_ff, l_in;
   logic [31:0] r_ff, r_in;
   logic [55:0] cd_ff, cd_in;
   logic [63:0] prev_ff, prev_in;
   logic        last_ff, last_in;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_data_ff, out_data_in;
   logic        out_last_ff, out_last_in;

   logic [31:0] l_rnd, r_rnd;
   logic [55:0] cd_rnd;
   logic [1:0]  rot_amt;
   logic [63:0] ip_out;
   logic        accept;
   logic        out_free;

   assign rot_amt = dcbc_pkg::SHIFT_TAB[~cnt_ff];

   dcbc_round u_round (
      .l_cur   (l_ff),
      .r_cur   (r_ff),
      .cd_cur  (cd_ff),
      .rot_amt (rot_amt),
      .l_next  (l_rnd),
      .r_next  (r_rnd),
      .cd_next (cd_rnd)
   );

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign accept          = req_ch.valid && req_ch.ready;
   assign out_free        = !out_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.plain_block = out_data_ff;
   assign rsp_ch.last_out = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      key_in       = key_ff;
      iv_in        = iv_ff;
      chain_in     = chain_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      cd_in        = cd_ff;
      prev_in      = prev_ff;
      last_in      = last_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      ip_out       = dcbc_pkg::ip_perm(req_ch.cipher_block);

      if (csr_we) begin
         unique case (csr_index)
            dcbc_pkg::CSR_DES_KEY:     key_in = csr_wdata;
            dcbc_pkg::CSR_INIT_VECTOR: iv_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               l_in     = ip_out[63:32];
               r_in     = ip_out[31:0];
               cd_in    = dcbc_pkg::pc1_perm(key_ff);
               prev_in  = req_ch.start_of_message ? iv_ff : chain_ff;
               chain_in = req_ch.cipher_block;
               last_in  = req_ch.last_block;
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            l_in   = l_rnd;
            r_in   = r_rnd;
            cd_in  = cd_rnd;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(dcbc_pkg::ROUNDS - 1)) state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold until the output register is empty or being drained
            if (out_free) begin
               out_data_in  = dcbc_pkg::fp_perm({r_ff, l_ff}) ^ prev_ff;
               out_last_in  = last_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         key_ff       <= '0;
         iv_ff        <= '0;
         chain_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         key_ff       <= key_in;
         iv_ff        <= iv_in;
         chain_ff     <= chain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff        <= l_in;
      r_ff        <= r_in;
      cd_ff       <= cd_in;
      prev_ff     <= prev_in;
      last_ff     <= last_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

endmodule

// File: rtl/dcbc_round.sv
// One DES decryption round: Feistel function plus the reverse key-schedule step.
module dcbc_round (
   input  logic [31:0] l_cur,
   input  logic [31:0] r_cur,
   input  logic [55:0] cd_cur,
   input  logic [1:0]  rot_amt,
   output logic [31:0] l_next,
   output logic [31:0] r_next,
   output logic [55:0] cd_next
);

   logic [47:0] round_key;
   logic [47:0] mixed;
   logic [31:0] f_out;

   always_comb begin
      round_key = dcbc_pkg::pc2_perm(cd_cur);
      mixed     = dcbc_pkg::expand(r_cur) ^ round_key;
      f_out     = dcbc_pkg::p_perm(dcbc_pkg::sbox_layer(mixed));
      l_next    = r_cur;
      r_next    = l_cur ^ f_out;
      // walk the key schedule backward: rotate right by this round's shift
      cd_next   = {dcbc_pkg::rotr28(cd_cur[55:28], rot_amt),
                   dcbc_pkg::rotr28(cd_cur[27:0], rot_amt)};
   end

endmodule
